/* rtl/sha256_message_digest_defines.svh */
// Assertion macros for the SHA-256 digest block.
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, a, c)
`define SHA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/sha_pkg.sv */
package sha_pkg;

	typedef logic [31:0] word_t;

	// Command passed from front to back.
	typedef enum logic [1:0] {
		CMD_BLOCK = 2'd0,
		CMD_FINAL = 2'd1,
		CMD_FINAL_TWO = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [15:0][31:0] blk;
		logic [15:0][31:0] blk2;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROUND,
		BK_ADD,
		BK_OUT
	} bk_state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic word_t iv(input logic [2:0] i);
		case (i)
			3'd0: iv = 32'h6a09e667;
			3'd1: iv = 32'hbb67ae85;
			3'd2: iv = 32'h3c6ef372;
			3'd3: iv = 32'ha54ff53a;
			3'd4: iv = 32'h510e527f;
			3'd5: iv = 32'h9b05688c;
			3'd6: iv = 32'h1f83d9ab;
			default: iv = 32'h5be0cd19;
		endcase
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		case (t)
			6'd0: round_k = 32'h428a2f98; 6'd1: round_k = 32'h71374491;
			6'd2: round_k = 32'hb5c0fbcf; 6'd3: round_k = 32'he9b5dba5;
			6'd4: round_k = 32'h3956c25b; 6'd5: round_k = 32'h59f111f1;
			6'd6: round_k = 32'h923f82a4; 6'd7: round_k = 32'hab1c5ed5;
			6'd8: round_k = 32'hd807aa98; 6'd9: round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

/* rtl/sha_front.sv */
module sha_front import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] message_byte,
	input  logic       byte_present,
	input  logic       final_item,
	input  logic       in_take,
	output logic       job_push,
	output job_t       job
);

	logic [15:0][31:0] blk_q;
	logic [60:0]       count_q;
	logic [15:0][31:0] nb;
	logic [60:0]       nc;
	logic [5:0]        pos;
	logic [3:0]        idx;
	logic [1:0]        lane;
	logic [63:0]       bits;

	always_comb begin
		nb = blk_q;
		nc = count_q;
		job_push = 1'b0;
		job.cmd = CMD_BLOCK;
		job.blk = blk_q;
		job.blk2 = '0;
		bits = '0;
		pos = count_q[5:0];
		idx = pos[5:2];
		lane = pos[1:0];
		if (in_take && byte_present) begin
			nb[idx][8*(3-lane) +: 8] = message_byte;
			nc = count_q + 61'd1;
			if (pos == 6'd63 && !final_item) begin
				job_push = 1'b1;
				job.blk = nb;
			end
		end
		if (in_take && final_item) begin
			pos = nc[5:0];
			idx = pos[5:2];
			lane = pos[1:0];
			if (byte_present && count_q[5:0] == 6'd63) begin
				// full block emitted along with a pure padding block
				job.blk = nb;
				job.blk2 = '0;
				job.blk2[0] = {PAD_BYTE, 24'd0};
				bits = {nc, 3'd0};
				job.blk2[14] = bits[63:32];
				job.blk2[15] = bits[31:0];
				job.cmd = CMD_FINAL_TWO;
			end else begin
				for (int i = 0; i < 16; i++) begin
					if (i[3:0] > idx) nb[i] = '0;
				end
				nb[idx][8*(3-lane) +: 8] = PAD_BYTE;
				for (int l = 0; l < 4; l++) begin
					if (l[1:0] > lane) nb[idx][8*(3-l) +: 8] = 8'd0;
				end
				bits = {nc, 3'd0};
				if (pos >= 6'd56) begin
					job.blk = nb;
					job.blk2 = '0;
					job.blk2[14] = bits[63:32];
					job.blk2[15] = bits[31:0];
					job.cmd = CMD_FINAL_TWO;
				end else begin
					job.blk = nb;
					job.blk[14] = bits[63:32];
					job.blk[15] = bits[31:0];
					job.cmd = CMD_FINAL;
				end
			end
			job_push = 1'b1;
			nc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= nc;
		end
	end

	always_ff @(posedge clk) begin
		blk_q <= nb;
	end

endmodule

/* rtl/sha_back.sv */
module sha_back import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	output logic        busy,
	output logic        out_valid,
	output logic [31:0] out_word,
	output logic [2:0]  out_num,
	input  logic        out_pop
);

	bk_state_t         state_q, state_d;
	logic [7:0][31:0]  h_q;
	logic [7:0][31:0]  v_q;
	logic [15:0][31:0] w_q;
	logic [15:0][31:0] pend_q;
	logic              second_q;
	logic              fin_q;
	logic [5:0]        rnd_q;
	logic [2:0]        onum_q;
	word_t             s0, s1, wn, t1, t2, b0, b1, ch, mj;

	always_comb begin
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		wn = s1 + w_q[9] + s0 + w_q[0];
		b1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + b1 + ch + round_k(rnd_q) + w_q[0];
		b0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = b0 + mj;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (job_valid) state_d = BK_ROUND;
			BK_ROUND: if (rnd_q == 6'd63) state_d = BK_ADD;
			BK_ADD: begin
				if (second_q) state_d = BK_ROUND;
				else if (fin_q) state_d = BK_OUT;
				else state_d = BK_IDLE;
			end
			BK_OUT:   if (out_pop && onum_q == 3'd7) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (state_q == BK_IDLE) && job_valid;
		busy = (state_q != BK_IDLE);
		out_valid = (state_q == BK_OUT);
		out_word = h_q[onum_q];
		out_num = onum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rnd_q <= '0;
			onum_q <= '0;
			second_q <= 1'b0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= iv(i[2:0]);
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE: begin
					rnd_q <= '0;
					onum_q <= '0;
					if (job_valid) begin
						second_q <= (job.cmd == CMD_FINAL_TWO);
						fin_q <= (job.cmd != CMD_BLOCK);
					end
				end
				BK_ROUND: rnd_q <= rnd_q + 6'd1;
				BK_ADD: begin
					second_q <= 1'b0;
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				BK_OUT: begin
					if (out_pop) begin
						onum_q <= onum_q + 3'd1;
						if (onum_q == 3'd7)
							for (int i = 0; i < 8; i++) h_q[i] <= iv(i[2:0]);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				w_q <= job.blk;
				pend_q <= job.blk2;
				v_q <= h_q;
			end
			BK_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wn;
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			BK_ADD: begin
				w_q <= pend_q;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i] + v_q[i];
			end
			default: ;
		endcase
	end

endmodule

/* rtl/sha256_message_digest.sv */
// SHA-256 over a byte stream. The front packs bytes into a 16-word block and
// builds padded final blocks; a two-entry job queue feeds the back, which runs
// one compression round per cycle. Bytes that fill blocks go in at about one byte per
// cycle while the queue has room, and at most two blocks on the final beat,
// followed by eight digest beats. Input is held off while the job queue is full
// and from a final beat until its last digest beat has been taken.
`include "sha256_message_digest_defines.svh"
module sha256_message_digest import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        final_item,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        last_word
);

	job_t       fq_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       in_take, job_push, job_pop, busy, out_valid;
	job_t       job;
	logic       fin_pend_q;

	// a final beat is not taken while a digest is still owed
	assign full = (cnt_q == 2'd2) || fin_pend_q;
	assign in_take = push && !full;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .message_byte(message_byte),
		.byte_present(byte_present), .final_item(final_item),
		.in_take(in_take), .job_push(job_push), .job(job)
	);

	sha_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(cnt_q != 2'd0), .job(fq_q[rd_q]),
		.job_pop(job_pop), .busy(busy), .out_valid(out_valid),
		.out_word(digest_word), .out_num(word_number), .out_pop(pop)
	);

	assign empty = !out_valid;
	assign last_word = (word_number == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
			fin_pend_q <= 1'b0;
		end else begin
			if (job_push) wr_q <= !wr_q;
			if (job_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, job_push} - {1'b0, job_pop};
			if (in_take && final_item) fin_pend_q <= 1'b1;
			else if (out_valid && pop && word_number == 3'd7) fin_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) fq_q[wr_q] <= job;
	end

	`SHA_ASSERT_IMP(a_no_overflow, clk, arst_n, job_push, cnt_q != 2'd2)
	`SHA_ASSERT_IMP(a_out_owed, clk, arst_n, out_valid, fin_pend_q)
	`SHA_ASSERT_NXT(a_pop_busy, clk, arst_n, job_pop, busy)

endmodule
